[sv/mhpd_pkg.sv]
// shared types, constants and field layout for the motor homing pwm drive
package mhpd_pkg;

   // parameter defaults
   localparam int COUNT_WIDTH_DEF = 32;
   localparam int TIMER_WIDTH_DEF = 16;

   // input transaction layout
   localparam int COUNT_FIELD_W = 32;
   localparam int FORCE_FIELD_W = 16;
   localparam int FORCE_LSB     = COUNT_FIELD_W;
   localparam int REQ_DATA_W    = 48;

   // result transaction layout
   localparam int PWM_W          = 8;
   localparam int POS_W          = 16;
   localparam int RSP_FIELDS_W   = 2 * PWM_W + 1 + POS_W + 2 * COUNT_FIELD_W;
   localparam int RSP_DATA_W     = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W      = RSP_DATA_W - RSP_FIELDS_W;

   // position divider: 15 fraction bits plus one overflow bit
   localparam int POS_FRAC_W     = POS_W - 1;
   localparam int DIV_STEPS      = POS_FRAC_W + 1;
   localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

   // configuration port
   localparam int CSR_INDEX_W    = 3;
   localparam int CSR_DATA_W     = 16;
   localparam int TICKS_W        = 16;
   localparam int THRESH_W       = 15;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEADBAND  = 3'd0,
      CSR_THRESHOLD = 3'd1,
      CSR_SETTLE    = 3'd2,
      CSR_SAMPLE    = 3'd3,
      CSR_STEP      = 3'd4,
      CSR_TOLERANCE = 3'd5
   } csr_index_type;

   localparam logic [PWM_W-1:0]    DEADBAND_RST  = 8'd150;
   localparam logic [THRESH_W-1:0] THRESHOLD_RST = 15'd328;
   localparam logic [TICKS_W-1:0]  SETTLE_RST    = 16'd1000;
   localparam logic [TICKS_W-1:0]  SAMPLE_RST    = 16'd100;
   localparam logic [TICKS_W-1:0]  STEP_RST      = 16'd20;
   localparam logic [TICKS_W-1:0]  TOLERANCE_RST = 16'd10;

   localparam logic [PWM_W-1:0] PWM_FULL = 8'd255;

   typedef struct packed {
      logic [PWM_W-1:0]    deadband;
      logic [THRESH_W-1:0] force_threshold;
      logic [TICKS_W-1:0]  settle_ticks;
      logic [TICKS_W-1:0]  sample_ticks;
      logic [TICKS_W-1:0]  step_ticks;
      logic [TICKS_W-1:0]  center_tolerance;
   } cfg_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic step;
      logic check;
      logic div_init;
      logic div_step;
      logic out_load;
   } cmd_type;

endpackage

[sv/mhpd_csr.sv]
// configuration register bank for the motor homing pwm drive
module mhpd_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [mhpd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [mhpd_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output mhpd_pkg::cfg_type                  cfg
);
   import mhpd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_DEADBAND:  cfg_in.deadband         = csr_wdata[PWM_W-1:0];
            CSR_THRESHOLD: cfg_in.force_threshold  = csr_wdata[THRESH_W-1:0];
            CSR_SETTLE:    cfg_in.settle_ticks     = csr_wdata[TICKS_W-1:0];
            CSR_SAMPLE:    cfg_in.sample_ticks     = csr_wdata[TICKS_W-1:0];
            CSR_STEP:      cfg_in.step_ticks       = csr_wdata[TICKS_W-1:0];
            CSR_TOLERANCE: cfg_in.center_tolerance = csr_wdata[TICKS_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.deadband         <= DEADBAND_RST;
         cfg_ff.force_threshold  <= THRESHOLD_RST;
         cfg_ff.settle_ticks     <= SETTLE_RST;
         cfg_ff.sample_ticks     <= SAMPLE_RST;
         cfg_ff.step_ticks       <= STEP_RST;
         cfg_ff.center_tolerance <= TOLERANCE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[sv/mhpd_ctrl.sv]
// per-transaction sequencer for the motor homing pwm drive
module mhpd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output mhpd_pkg::cmd_type cmd
);
   import mhpd_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_STEP  = 6'b000010,
      S_CHECK = 6'b000100,
      S_DINIT = 6'b001000,
      S_DSTEP = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type              state_ff, state_in;
   logic [DIV_CNT_W-1:0]   div_cnt_ff, div_cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      div_cnt_in   = div_cnt_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            cmd.step = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = S_DINIT;
         end
         S_DINIT: begin
            cmd.div_init = 1'b1;
            div_cnt_in   = '0;
            state_in     = S_DSTEP;
         end
         S_DSTEP: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + DIV_CNT_W'(1);
            if (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // result register free or emptying this cycle
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

[sv/mhpd_dpath.sv]
// homing state, pwm drive and serial position divider for the motor drive
module mhpd_dpath #(
   parameter int COUNT_WIDTH = mhpd_pkg::COUNT_WIDTH_DEF,
   parameter int TIMER_WIDTH = mhpd_pkg::TIMER_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  mhpd_pkg::cmd_type                 cmd,
   input  mhpd_pkg::cfg_type                 cfg,
   input  logic [mhpd_pkg::REQ_DATA_W-1:0]   req_data,
   input  logic                              req_start,
   output logic [mhpd_pkg::RSP_DATA_W-1:0]   rsp_data
);
   import mhpd_pkg::*;

   localparam int CW    = COUNT_WIDTH;
   localparam int DW    = COUNT_WIDTH + 1;
   localparam int TOL_W = (DW > TICKS_W) ? DW : TICKS_W;

   typedef enum logic [5:0] {
      PH_IDLE    = 6'b000001,
      PH_LSETTLE = 6'b000010,
      PH_LSAMPLE = 6'b000100,
      PH_RSETTLE = 6'b001000,
      PH_RSAMPLE = 6'b010000,
      PH_CENTER  = 6'b100000
   } phase_type;

   // halve toward zero
   function automatic logic signed [CW-1:0] half_tz(input logic signed [DW-1:0] v);
      logic signed [DW-1:0] adj;
      adj = v + DW'(v[DW-1]);
      return adj[DW-1:1];
   endfunction

   // latched transaction
   logic signed [CW-1:0]     cnt_ff;
   logic [THRESH_W-1:0]      mag_ff;
   logic                     fneg_ff;
   logic                     start_ff;

   // homing state
   phase_type                phase_ff, phase_in;
   logic [TIMER_WIDTH-1:0]   timer_ff, timer_in;
   logic signed [CW-1:0]     last_ff, last_in;
   logic                     first_ff, first_in;
   logic signed [CW-1:0]     left_ff, left_in;
   logic signed [CW-1:0]     center_ff, center_in;
   logic signed [CW-1:0]     range_ff, range_in;
   logic                     pend_ff, pend_in;
   logic [PWM_W-1:0]         pwm_a_ff, pwm_a_in;
   logic [PWM_W-1:0]         pwm_b_ff, pwm_b_in;
   logic                     busy_ff, busy_in;

   // divider
   logic [DW-1:0]            rem_ff, rem_in;
   logic [CW-1:0]            den_ff, den_in;
   logic [POS_W-1:0]         quo_ff, quo_in;
   logic                     qneg_ff, qneg_in;
   logic                     zero_ff, zero_in;

   logic [RSP_DATA_W-1:0]    rsp_data_ff;

   // load-side force magnitude
   logic signed [FORCE_FIELD_W-1:0] force_raw;
   logic [FORCE_FIELD_W-1:0]        force_abs;
   logic [THRESH_W-1:0]             force_mag;

   always_comb begin
      force_raw = req_data[FORCE_LSB +: FORCE_FIELD_W];
      force_abs = force_raw[FORCE_FIELD_W-1] ? -force_raw : force_raw;
      // most negative code clamps to full scale
      force_mag = force_abs[FORCE_FIELD_W-1] ? '1 : force_abs[THRESH_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cnt_ff   <= req_data[CW-1:0];
         mag_ff   <= force_mag;
         fneg_ff  <= force_raw[FORCE_FIELD_W-1];
         start_ff <= req_start;
      end
   end

   // homing sequence, drive and centering check
   logic                      expired;
   logic [TIMER_WIDTH-1:0]    timer_dec;
   logic                      same;
   logic                      first_eff;
   logic [2*PWM_W+THRESH_W-1:0] prod;
   logic [PWM_W:0]            duty_sum;
   logic [PWM_W-1:0]          duty;
   logic                      over;
   logic signed [DW-1:0]      dsum;
   logic signed [DW-1:0]      ddif;
   logic signed [DW-1:0]      cdif;
   logic [DW-1:0]             cabs;

   always_comb begin
      phase_in  = phase_ff;
      timer_in  = timer_ff;
      last_in   = last_ff;
      first_in  = first_ff;
      left_in   = left_ff;
      center_in = center_ff;
      range_in  = range_ff;
      pend_in   = pend_ff;
      pwm_a_in  = pwm_a_ff;
      pwm_b_in  = pwm_b_ff;
      busy_in   = busy_ff;

      expired   = (timer_ff <= TIMER_WIDTH'(1));
      timer_dec = expired ? '0 : timer_ff - TIMER_WIDTH'(1);
      same      = (cnt_ff == last_ff);
      first_eff = first_ff;
      prod      = (2*PWM_W+THRESH_W)'(mag_ff) * (2*PWM_W+THRESH_W)'(PWM_FULL);
      duty_sum  = {1'b0, cfg.deadband} + {1'b0, prod[THRESH_W +: PWM_W]};
      duty      = duty_sum[PWM_W] ? PWM_FULL : duty_sum[PWM_W-1:0];
      over      = (mag_ff > cfg.force_threshold);
      dsum      = DW'(left_ff) + DW'(cnt_ff);
      ddif      = DW'(cnt_ff) - DW'(left_ff);
      cdif      = DW'(cnt_ff) - DW'(center_ff);
      cabs      = cdif[DW-1] ? -cdif : cdif;

      if (cmd.step) begin
         pend_in = 1'b0;
         unique case (phase_ff)
            PH_IDLE: begin
               if (start_ff) begin
                  phase_in = PH_LSETTLE;
                  timer_in = TIMER_WIDTH'(cfg.settle_ticks);
                  pwm_a_in = PWM_FULL;
                  pwm_b_in = '0;
                  busy_in  = 1'b1;
               end else begin
                  pwm_a_in = (fneg_ff && over) ? duty : '0;
                  pwm_b_in = (!fneg_ff && over) ? duty : '0;
                  busy_in  = 1'b0;
               end
            end
            PH_LSETTLE, PH_LSAMPLE: begin
               pwm_a_in = PWM_FULL;
               pwm_b_in = '0;
               busy_in  = 1'b1;
               timer_in = timer_dec;
               if (expired) begin
                  first_eff = first_ff || (phase_ff == PH_LSETTLE);
                  phase_in  = PH_LSAMPLE;
                  if (!first_eff && same) begin
                     left_in  = cnt_ff;
                     phase_in = PH_RSETTLE;
                     timer_in = TIMER_WIDTH'(cfg.settle_ticks);
                     pwm_a_in = '0;
                     pwm_b_in = PWM_FULL;
                  end else begin
                     first_in = 1'b0;
                     last_in  = cnt_ff;
                     timer_in = TIMER_WIDTH'(cfg.sample_ticks);
                  end
               end
            end
            PH_RSETTLE, PH_RSAMPLE: begin
               pwm_a_in = '0;
               pwm_b_in = PWM_FULL;
               busy_in  = 1'b1;
               timer_in = timer_dec;
               if (expired) begin
                  first_eff = first_ff || (phase_ff == PH_RSETTLE);
                  phase_in  = PH_RSAMPLE;
                  if (!first_eff && same) begin
                     // right stop: store center and half range, check next cycle
                     center_in = half_tz(dsum);
                     range_in  = half_tz(ddif);
                     phase_in  = PH_CENTER;
                     pend_in   = 1'b1;
                  end else begin
                     first_in = 1'b0;
                     last_in  = cnt_ff;
                     timer_in = TIMER_WIDTH'(cfg.sample_ticks);
                  end
               end
            end
            PH_CENTER: begin
               busy_in  = 1'b1;
               timer_in = timer_dec;
               if (expired) begin
                  pend_in = 1'b1;
               end else begin
                  pwm_a_in = (cnt_ff < center_ff) ? '0 : PWM_FULL;
                  pwm_b_in = (cnt_ff < center_ff) ? PWM_FULL : '0;
               end
            end
            default: begin
               phase_in = PH_IDLE;
               pwm_a_in = '0;
               pwm_b_in = '0;
               busy_in  = 1'b0;
            end
         endcase
      end

      if (cmd.check && pend_ff) begin
         pend_in = 1'b0;
         if (TOL_W'(cabs) <= TOL_W'(cfg.center_tolerance)) begin
            pwm_a_in = '0;
            pwm_b_in = '0;
            phase_in = PH_IDLE;
            busy_in  = 1'b0;
         end else begin
            pwm_a_in = (cnt_ff < center_ff) ? '0 : PWM_FULL;
            pwm_b_in = (cnt_ff < center_ff) ? PWM_FULL : '0;
            timer_in = TIMER_WIDTH'(cfg.step_ticks);
            phase_in = PH_CENTER;
            busy_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         timer_ff  <= '0;
         last_ff   <= '0;
         first_ff  <= 1'b1;
         left_ff   <= '0;
         center_ff <= '0;
         range_ff  <= '0;
         pend_ff   <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         timer_ff  <= timer_in;
         last_ff   <= last_in;
         first_ff  <= first_in;
         left_ff   <= left_in;
         center_ff <= center_in;
         range_ff  <= range_in;
         pend_ff   <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      pwm_a_ff <= pwm_a_in;
      pwm_b_ff <= pwm_b_in;
      busy_ff  <= busy_in;
   end

   // restoring divider: |center - cnt| * 2^15 / |range|, first bit flags overflow
   logic signed [DW-1:0] pdif;
   logic [DW-1:0]        pabs;
   logic                 fits;
   logic [DW-1:0]        rem_sub;

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      qneg_in = qneg_ff;
      zero_in = zero_ff;
      pdif    = DW'(center_ff) - DW'(cnt_ff);
      pabs    = pdif[DW-1] ? -pdif : pdif;
      fits    = (rem_ff >= DW'(den_ff));
      rem_sub = rem_ff - (fits ? DW'(den_ff) : '0);
      if (cmd.div_init) begin
         rem_in  = pabs;
         den_in  = range_ff[CW-1] ? -range_ff : range_ff;
         quo_in  = '0;
         qneg_in = pdif[DW-1] ^ range_ff[CW-1];
         zero_in = (range_ff == '0);
      end else if (cmd.div_step) begin
         rem_in = {rem_sub[DW-2:0], 1'b0};
         quo_in = {quo_ff[POS_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
      qneg_ff <= qneg_in;
      zero_ff <= zero_in;
   end

   // result packing
   logic [POS_W-1:0]         pos_mag;
   logic signed [POS_W-1:0]  pos_val;

   always_comb begin
      pos_mag = quo_ff[POS_W-1] ? {1'b0, {POS_FRAC_W{1'b1}}} : {1'b0, quo_ff[POS_W-2:0]};
      if (zero_ff) begin
         pos_val = '0;
      end else begin
         pos_val = qneg_ff ? -pos_mag : pos_mag;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff <= {{RSP_PAD_W{1'b0}},
                         COUNT_FIELD_W'(range_ff),
                         COUNT_FIELD_W'(center_ff),
                         pos_val,
                         busy_ff,
                         pwm_b_ff,
                         pwm_a_ff};
      end
   end

   assign rsp_data = rsp_data_ff;

endmodule

[sv/motor_homing_pwm_drive_unit.sv]
// top level of the stall homing and deadband pwm h-bridge drive
//
//  channel  | handshake                | payload
//  ---------+--------------------------+------------------------------------------------
//  req      | req_tvalid / req_tready  | tdata: encoder_count, force_req; tuser: start_home
//  rsp      | rsp_tvalid / rsp_tready  | tdata: pwm_a, pwm_b, homing_busy, position,
//           |                          |        center_count, half_range
//  csr      | csr_we (no wait)         | csr_index, csr_wdata
//
// one transaction at a time: after acceptance the sequencer runs load, homing step,
// centering check, divider setup and the 16-step serial divider for the position,
// then loads the result. the result sits in an output register, so the next
// transaction is taken while it waits for rsp_tready. synchronous active-high
// reset returns the homing state, configuration registers and sequencer to their
// defaults, not the drive levels, divider or result register; there is no clearing pass.
module motor_homing_pwm_drive_unit #(
   parameter int COUNT_WIDTH = mhpd_pkg::COUNT_WIDTH_DEF,
   parameter int TIMER_WIDTH = mhpd_pkg::TIMER_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [31:0] encoder_count, [47:32] force_req
   input  logic [mhpd_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [0] start_home
   input  logic                               req_tuser,

   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [7:0] pwm_a, [15:8] pwm_b, [16] homing_busy, [32:17] position,
   // [64:33] center_count, [96:65] half_range, [103:97] zero
   output logic [mhpd_pkg::RSP_DATA_W-1:0]    rsp_tdata,

   input  logic                               csr_we,
   input  logic [mhpd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [mhpd_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import mhpd_pkg::*;

   cfg_type cfg;   // live register values
   cmd_type cmd;   // per-cycle sequencer commands

   mhpd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // sequencer: accept, homing step, centering check, divide, hand off
   mhpd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // homing state, drive levels, position divider and result register
   mhpd_dpath #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cfg       (cfg),
      .req_data  (req_tdata),
      .req_start (req_tuser),
      .rsp_data  (rsp_tdata)
   );

endmodule

[bench/tb_top.sv]
// self-checking bench for the stall homing and deadband pwm drive unit
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mhpd_pkg::*;

   // run limits, reckoned generously from the slowest legal run
   localparam int     CYCLE_LIMIT  = 600000;
   localparam int     DRAIN_CYCLES = 40;
   localparam int     PHASE_ITEMS  = 250;
   localparam int     MAX_REPORTS  = 100;
   localparam int     PARK_GUARD   = 400;
   localparam longint INT32_MAX    = 64'sd2147483647;
   localparam longint INT32_MIN    = -64'sd2147483648;

   // register slots past the last defined one, writes must be ignored
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;

   // homing sequencer states of the predictor
   typedef enum logic [2:0] {
      HOME_IDLE,
      HOME_LEFT_SETTLE,
      HOME_LEFT_SAMPLE,
      HOME_RIGHT_SETTLE,
      HOME_RIGHT_SAMPLE,
      HOME_CENTER
   } home_state_type;

   // one millisecond tick as sent on the request channel
   typedef struct {
      logic [COUNT_FIELD_W-1:0] count;
      logic [FORCE_FIELD_W-1:0] force_cmd;
      logic                     start;
   } tick_item_type;

   // one drive result as expected on the response channel
   typedef struct {
      logic [PWM_W-1:0]         pwm_a;
      logic [PWM_W-1:0]         pwm_b;
      logic                     busy;
      logic [POS_W-1:0]         position;
      logic [COUNT_FIELD_W-1:0] center;
      logic [COUNT_FIELD_W-1:0] half;
   } drive_result_type;

   // dut ports, every input known from time zero
   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic                   req_tuser  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   // bench bookkeeping
   tick_item_type    tick_queue[$];
   drive_result_type expected_drive[$];
   logic          req_taken     = 1'b0;
   int            error_count   = 0;
   int            cycle_count   = 0;
   int            queued_items  = 0;
   int            send_gap_pct  = 0;
   int            rsp_stall_pct = 0;

   // predictor copy of the registers and the homing state
   cfg_type       drive_cfg;
   home_state_type home_state;
   logic [TICKS_W-1:0] tick_timer;
   longint        prev_count;
   bit            first_sample;
   longint        left_stop;
   longint        right_stop;
   longint        center_count;
   longint        half_range;

   motor_homing_pwm_drive_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------

   function automatic void model_reset();
      drive_cfg.deadband         = DEADBAND_RST;
      drive_cfg.force_threshold  = THRESHOLD_RST;
      drive_cfg.settle_ticks     = SETTLE_RST;
      drive_cfg.sample_ticks     = SAMPLE_RST;
      drive_cfg.step_ticks       = STEP_RST;
      drive_cfg.center_tolerance = TOLERANCE_RST;
      home_state   = HOME_IDLE;
      tick_timer   = '0;
      prev_count   = 0;
      first_sample = 1'b1;
      left_stop    = 0;
      right_stop   = 0;
      center_count = 0;
      half_range   = 0;
   endfunction

   function automatic void apply_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_DEADBAND:  drive_cfg.deadband         = val[PWM_W-1:0];
         CSR_THRESHOLD: drive_cfg.force_threshold  = val[THRESH_W-1:0];
         CSR_SETTLE:    drive_cfg.settle_ticks     = val;
         CSR_SAMPLE:    drive_cfg.sample_ticks     = val;
         CSR_STEP:      drive_cfg.step_ticks       = val;
         CSR_TOLERANCE: drive_cfg.center_tolerance = val;
         default: ;
      endcase
   endfunction

   // count down one tick, a loaded zero expires just like a one
   function automatic bit timer_expired();
      if (tick_timer <= 1) begin
         tick_timer = '0;
         return 1'b1;
      end
      tick_timer = tick_timer - 1'b1;
      return 1'b0;
   endfunction

   // first sample of a direction only records, later ones compare
   function automatic bit count_stalled(longint cnt);
      if (!first_sample && cnt == prev_count) return 1'b1;
      first_sample = 1'b0;
      prev_count   = cnt;
      tick_timer   = drive_cfg.sample_ticks;
      return 1'b0;
   endfunction

   function automatic void steer_to_center(longint cnt, output logic [PWM_W-1:0] a,
                                           output logic [PWM_W-1:0] b);
      if (cnt < center_count) begin
         a = '0;
         b = PWM_FULL;
      end else begin
         a = PWM_FULL;
         b = '0;
      end
   endfunction

   // true while centering continues
   function automatic bit center_check(longint cnt, output logic [PWM_W-1:0] a,
                                       output logic [PWM_W-1:0] b);
      longint from_center;
      from_center = cnt - center_count;
      if (from_center < 0) from_center = -from_center;
      if (from_center <= longint'(drive_cfg.center_tolerance)) begin
         a = '0;
         b = '0;
         home_state = HOME_IDLE;
         return 1'b0;
      end
      steer_to_center(cnt, a, b);
      tick_timer = drive_cfg.step_ticks;
      home_state = HOME_CENTER;
      return 1'b1;
   endfunction

   function automatic drive_result_type next_drive_result(logic [COUNT_FIELD_W-1:0] count_bits,
                                                          logic [FORCE_FIELD_W-1:0] force_bits,
                                                          logic start);
      drive_result_type r;
      longint           cnt, f, mag, duty, pos;
      logic [PWM_W-1:0] a, b;
      bit               busy;
      cnt  = longint'($signed(count_bits));
      f    = longint'($signed(force_bits));
      a    = '0;
      b    = '0;
      busy = 1'b1;
      pos  = 0;
      // most negative force is clamped to keep the magnitude symmetric
      if (f < -32767) f = -32767;
      case (home_state)
         HOME_IDLE: begin
            if (start) begin
               home_state = HOME_LEFT_SETTLE;
               tick_timer = drive_cfg.settle_ticks;
               a = PWM_FULL;
            end else begin
               mag  = (f < 0) ? -f : f;
               duty = longint'(drive_cfg.deadband) + ((mag * 255) >> 15);
               if (duty > 255) duty = 255;
               if (f > longint'(drive_cfg.force_threshold)) b = duty[PWM_W-1:0];
               else if (f < -longint'(drive_cfg.force_threshold)) a = duty[PWM_W-1:0];
               busy = 1'b0;
            end
         end
         HOME_LEFT_SETTLE, HOME_LEFT_SAMPLE: begin
            a = PWM_FULL;
            if (timer_expired()) begin
               if (home_state == HOME_LEFT_SETTLE) begin
                  first_sample = 1'b1;
                  home_state   = HOME_LEFT_SAMPLE;
               end
               if (count_stalled(cnt)) begin
                  left_stop  = cnt;
                  home_state = HOME_RIGHT_SETTLE;
                  tick_timer = drive_cfg.settle_ticks;
                  a = '0;
                  b = PWM_FULL;
               end
            end
         end
         HOME_RIGHT_SETTLE, HOME_RIGHT_SAMPLE: begin
            b = PWM_FULL;
            if (timer_expired()) begin
               if (home_state == HOME_RIGHT_SETTLE) begin
                  first_sample = 1'b1;
                  home_state   = HOME_RIGHT_SAMPLE;
               end
               if (count_stalled(cnt)) begin
                  // both divisions truncate toward zero
                  right_stop   = cnt;
                  center_count = (left_stop + right_stop) / 2;
                  half_range   = (right_stop - left_stop) / 2;
                  busy = center_check(cnt, a, b);
               end
            end
         end
         HOME_CENTER: begin
            if (timer_expired()) busy = center_check(cnt, a, b);
            else steer_to_center(cnt, a, b);
         end
         default: begin
            home_state = HOME_IDLE;
            busy = 1'b0;
         end
      endcase
      // zero-centered position, uses center and range after this tick
      if (half_range != 0) begin
         pos = ((center_count - cnt) * 32768) / half_range;
         if (pos > 32767) pos = 32767;
         if (pos < -32767) pos = -32767;
      end
      r.pwm_a    = a;
      r.pwm_b    = b;
      r.busy     = busy;
      r.position = pos[POS_W-1:0];
      r.center   = center_count[COUNT_FIELD_W-1:0];
      r.half     = half_range[COUNT_FIELD_W-1:0];
      return r;
   endfunction

   // ------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
   endtask

   task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) report_mismatch(name, got, want);
   endtask

   // request side predicts on acceptance, result side compares in order
   always @(posedge clock) begin : monitor
      drive_result_type want;
      req_taken <= req_tvalid && req_tready;
      if (!reset) begin
         if (req_tvalid && req_tready)
            expected_drive.push_back(next_drive_result(req_tdata[COUNT_FIELD_W-1:0],
                                                       req_tdata[FORCE_LSB +: FORCE_FIELD_W],
                                                       req_tuser));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_drive.size() == 0) begin
               report_mismatch("result transaction with nothing expected", rsp_tdata[63:0], '0);
            end else begin
               want = expected_drive.pop_front();
               check_field("pwm_a", rsp_tdata[7:0], want.pwm_a);
               check_field("pwm_b", rsp_tdata[15:8], want.pwm_b);
               check_field("homing_busy", rsp_tdata[16], want.busy);
               check_field("position", rsp_tdata[32:17], want.position);
               check_field("center_count", rsp_tdata[64:33], want.center);
               check_field("half_range", rsp_tdata[96:65], want.half);
               check_field("pad bits", rsp_tdata[RSP_DATA_W-1:RSP_FIELDS_W], '0);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // driver: request side fed from tick_queue, response side stalls
   // ------------------------------------------------------------------

   always @(negedge clock) begin : driver
      tick_item_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         // slot is free, send the next tick unless this cycle idles
         if (tick_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
            item = tick_queue.pop_front();
            req_tdata  <= {item.force_cmd, item.count};
            req_tuser  <= item.start;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------

   function automatic longint clamp32(longint v);
      if (v > INT32_MAX) return INT32_MAX;
      if (v < INT32_MIN) return INT32_MIN;
      return v;
   endfunction

   function automatic longint ticks_or_one(logic [TICKS_W-1:0] v);
      return (v == 0) ? 1 : longint'(v);
   endfunction

   // force mix: full random, around the threshold, extremes, small values
   function automatic logic [FORCE_FIELD_W-1:0] pick_force();
      logic [FORCE_FIELD_W-1:0] thr;
      logic [FORCE_FIELD_W-1:0] near;
      thr = {1'b0, drive_cfg.force_threshold};
      case ($urandom_range(0, 3))
         0: return 16'($urandom);
         1: begin
            near = thr + 16'($urandom_range(0, 2)) - 16'd1;
            return $urandom_range(0, 1) ? near : -near;
         end
         2: begin
            case ($urandom_range(0, 3))
               0: return 16'h7fff;
               1: return 16'h8000;
               2: return 16'h8001;
               default: return 16'h0000;
            endcase
         end
         default: return 16'($urandom_range(0, 4000)) - 16'd2000;
      endcase
   endfunction

   task automatic push_tick(longint cnt, logic [FORCE_FIELD_W-1:0] f, logic start);
      tick_item_type item;
      item.count     = cnt[COUNT_FIELD_W-1:0];
      item.force_cmd = f;
      item.start     = start;
      tick_queue.push_back(item);
      queued_items++;
   endtask

   task automatic add_ramp(longint from, longint to, int steps);
      for (int i = 1; i <= steps; i++)
         push_tick(from + (to - from) * i / steps, pick_force(), 1'b0);
   endtask

   // encoder held still, mostly long enough for a stall to be seen
   task automatic add_plateau(longint cnt, longint len);
      int n;
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, int'(len))
                                      : int'(len) + $urandom_range(0, 3);
      repeat (n) push_tick(cnt, pick_force(), $urandom_range(0, 19) == 0);
   endtask

   // scripted motor: run to a left wall, then a right wall, then to center
   task automatic add_homing_run();
      longint lo, hi, home, mid, span, plateau, tol;
      lo = ($urandom_range(0, 3) == 0) ? longint'($signed($urandom))
                                       : longint'($urandom_range(0, 20000)) - 10000;
      span = ($urandom_range(0, 7) == 0) ? longint'($urandom) : longint'($urandom_range(0, 4000));
      hi   = clamp32(lo + span);
      home = clamp32(lo + longint'($urandom_range(0, 60)));
      if (home > hi) home = hi;
      plateau = ticks_or_one(drive_cfg.settle_ticks) + 2 * ticks_or_one(drive_cfg.sample_ticks) + 2;
      tol = longint'(drive_cfg.center_tolerance);
      push_tick(home, pick_force(), 1'b1);
      add_ramp(home, lo, $urandom_range(0, 4));
      add_plateau(lo, plateau);
      add_ramp(lo, hi, $urandom_range(1, 6));
      add_plateau(hi, plateau);
      // settle somewhere inside the tolerance window
      mid = clamp32((lo + hi) / 2 + longint'($urandom_range(0, int'(2 * tol))) - tol);
      add_ramp(hi, mid, $urandom_range(1, 6));
      add_plateau(mid, 3 * ticks_or_one(drive_cfg.step_ticks) + 2);
   endtask

   task automatic add_chunk();
      longint base;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5, 6: add_homing_run();
         7: begin
            // pure noise, any count, start now and then
            repeat ($urandom_range(5, 15))
               push_tick(longint'($signed($urandom)), pick_force(), $urandom_range(0, 5) == 0);
         end
         8: begin
            // homing started on an encoder that never settles
            push_tick(longint'($signed($urandom)), pick_force(), 1'b1);
            repeat ($urandom_range(5, 20))
               push_tick(longint'($urandom_range(0, 200)) - 100, pick_force(), 1'b0);
         end
         default: begin
            // manual drive around a fixed spot
            base = longint'($signed($urandom));
            repeat ($urandom_range(5, 15))
               push_tick(clamp32(base + longint'($urandom_range(0, 3))), pick_force(), 1'b0);
         end
      endcase
   endtask

   // poll just after the falling edge so driver and monitor have settled
   task automatic wait_for_quiet();
      do begin
         @(negedge clock);
         #1;
      end while (tick_queue.size() != 0 || req_tvalid || expected_drive.size() != 0);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      apply_csr(idx, val);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic write_timing(logic [TICKS_W-1:0] settle, logic [TICKS_W-1:0] sample,
                               logic [TICKS_W-1:0] step, logic [TICKS_W-1:0] tol);
      write_reg(CSR_SETTLE, settle);
      write_reg(CSR_SAMPLE, sample);
      write_reg(CSR_STEP, step);
      write_reg(CSR_TOLERANCE, tol);
   endtask

   // feed a still encoder one tick at a time until the sequencer is idle
   task automatic park_homing();
      int guard;
      guard = 0;
      while (home_state != HOME_IDLE && guard < PARK_GUARD) begin
         push_tick((home_state == HOME_CENTER) ? center_count : prev_count, pick_force(), 1'b0);
         wait_for_quiet();
         guard++;
      end
   endtask

   // ------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------

   initial begin : stimulus
      int gap_mode[4];
      int stall_mode[4];
      int mark;
      gap_mode   = '{0, 63, 0, 30};
      stall_mode = '{0, 0, 63, 30};
      model_reset();
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // manual drive at reset settings: threshold edges, force extremes
      push_tick(0, 16'd0, 1'b0);
      push_tick(INT32_MAX, 16'd328, 1'b0);
      push_tick(INT32_MIN, 16'd329, 1'b0);
      push_tick(-5, -16'sd328, 1'b0);
      push_tick(5, -16'sd329, 1'b0);
      push_tick(1, 16'h7fff, 1'b0);
      push_tick(-1, 16'h8001, 1'b0);
      push_tick(7, 16'h8000, 1'b0);
      wait_for_quiet();

      // full deadband with zero threshold: duty saturates, tiny force drives
      write_reg(CSR_DEADBAND, 16'd255);
      write_reg(CSR_THRESHOLD, 16'd0);
      push_tick(0, 16'd1, 1'b0);
      push_tick(0, 16'hffff, 1'b0);
      push_tick(0, 16'd0, 1'b0);
      push_tick(0, 16'h7fff, 1'b0);
      wait_for_quiet();

      // zero deadband, top threshold: nothing can exceed it
      write_reg(CSR_DEADBAND, 16'd0);
      write_reg(CSR_THRESHOLD, 16'h7fff);
      push_tick(0, 16'h7fff, 1'b0);
      push_tick(0, 16'h8000, 1'b0);
      wait_for_quiet();

      // zero timers act as one tick, zero tolerance needs an exact center
      write_timing(16'd0, 16'd0, 16'd0, 16'd0);
      push_tick(100, 16'd0, 1'b1);
      push_tick(100, 16'd0, 1'b0);
      push_tick(100, 16'd0, 1'b1);  // start while busy is ignored
      push_tick(300, 16'd0, 1'b0);
      push_tick(300, 16'd0, 1'b0);
      push_tick(250, 16'd0, 1'b0);
      push_tick(200, 16'd0, 1'b0);
      // idle after homing: position saturates both ways
      push_tick(0, 16'd5000, 1'b0);
      push_tick(400, 16'd0, 1'b0);
      push_tick(199, 16'd0, 1'b0);
      push_tick(INT32_MIN, 16'd0, 1'b0);
      wait_for_quiet();

      // random phases, each with its own settings and idling pattern
      for (int phase_no = 0; phase_no < 4; phase_no++) begin
         park_homing();
         send_gap_pct  = gap_mode[phase_no];
         rsp_stall_pct = stall_mode[phase_no];
         case ($urandom_range(0, 3))
            0: write_reg(CSR_DEADBAND, 16'd0);
            1: write_reg(CSR_DEADBAND, 16'd255);
            default: write_reg(CSR_DEADBAND, 16'($urandom_range(0, 255)));
         endcase
         case ($urandom_range(0, 3))
            0: write_reg(CSR_THRESHOLD, 16'd0);
            1: write_reg(CSR_THRESHOLD, 16'h7fff);
            default: write_reg(CSR_THRESHOLD, 16'($urandom_range(0, 3000)));
         endcase
         write_timing(16'($urandom_range(0, 6)), 16'($urandom_range(0, 4)),
                      16'($urandom_range(0, 5)),
                      (phase_no == 2) ? 16'hffff : 16'($urandom_range(0, 40)));
         if (phase_no == 1) begin
            write_reg(CSR_SPARE_LO, 16'($urandom));
            write_reg(CSR_SPARE_HI, 16'($urandom));
         end
         mark = queued_items;
         while (queued_items - mark < PHASE_ITEMS) begin
            add_chunk();
            // halfway through the last phase, hold the sender until all results are in
            if (phase_no == 3 && queued_items - mark >= PHASE_ITEMS / 2 &&
                queued_items - mark < PHASE_ITEMS / 2 + 30) begin
               wait_for_quiet();
               mark = mark - 30;
            end
         end
         wait_for_quiet();
      end

      // longest timers and widest tolerance, manual drive only
      park_homing();
      write_timing(16'hffff, 16'hffff, 16'hffff, 16'hffff);
      write_reg(CSR_DEADBAND, 16'd255);
      write_reg(CSR_THRESHOLD, 16'd0);
      repeat (20) push_tick(longint'($signed($urandom)), pick_force(), 1'b0);
      wait_for_quiet();

      // let any late transaction show up before judging
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_drive.size() != 0)
         report_mismatch("results never returned", expected_drive.size(), '0);
      if (error_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
